// ----- rtl/rtce_pkg.sv -----
// ============================================================================
// rtce_pkg
// Shared types, register indexes and calendar constants for the clock-chip
// snapshot to epoch seconds converter.
// ============================================================================
package rtce_pkg;

    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 7;

    localparam logic [CfgIdxW-1:0] CFG_BINARY_MODE  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HOUR_24_MODE = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_CENTURY      = 2'd2;

    localparam int unsigned YearW  = 14;
    localparam int unsigned DaysW  = 22;
    localparam int unsigned HmsW   = 20;
    localparam int unsigned EpochW = 40;

    localparam logic [YearW-1:0] EPOCH_YEAR  = 14'd1970;
    localparam logic [YearW-1:0] YEAR_2000   = 14'd2000;
    localparam logic [YearW-1:0] YEAR_1900   = 14'd1900;
    localparam logic [7:0]       WINDOW_YEAR = 8'd80;
    // leap days in years 1..1969
    localparam logic [11:0]      LEAPS_BEFORE_EPOCH = 12'd477;
    localparam logic [16:0]      SECS_PER_DAY = 17'd86400;

    // floor(x / 25) = (x * RECIP_25) >> 16, exact for x < 4681
    localparam logic [11:0]      RECIP_25 = 12'd2622;

    typedef struct packed {
        logic [7:0] raw_second;
        logic [7:0] raw_minute;
        logic [7:0] raw_hour;
        logic [7:0] raw_weekday;
        logic [7:0] raw_day;
        logic [7:0] raw_month;
        logic [7:0] raw_year;
    } t_rtc_in;

    typedef struct packed {
        logic [EpochW-1:0] epoch_seconds;
        logic [YearW-1:0]  full_year;
        logic [7:0]        month_number;
        logic [7:0]        day_of_month;
        logic [7:0]        day_of_week;
        logic [7:0]        hour_of_day;
        logic [7:0]        minute_of_hour;
        logic [7:0]        second_of_minute;
        logic              date_valid;
    } t_rtc_out;

    typedef struct packed {
        logic                binary_mode;
        logic                hour_24_mode;
        logic [CfgDataW-1:0] century;
    } t_rtc_cfg;

    function automatic logic [7:0] decode_byte(input logic [7:0] v, input logic bin);
        logic [7:0] hi;
        hi = {4'd0, v[7:4]};
        decode_byte = bin ? v : ((hi << 3) + (hi << 1) + {4'd0, v[3:0]});
    endfunction

    // days in the months before month m, common year
    function automatic logic [8:0] month_offset(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        month_offset = d;
    endfunction

endpackage

// ----- rtl/rtce_decode.sv -----
// ============================================================================
// rtce_decode
// Decodes one register snapshot: BCD or binary bytes, 12/24-hour hour,
// full year from century or windowing, and the date check.
// ============================================================================
module rtce_decode (
    input  rtce_pkg::t_rtc_cfg i_cfg,
    input  rtce_pkg::t_rtc_in  i_raw,
    output rtce_pkg::t_rtc_out o_fld
);

    logic [7:0] w_sec, w_min, w_wday, w_day, w_mon, w_yy;
    logic [7:0] w_h24, w_h12, w_h12z, w_hour;
    logic [rtce_pkg::YearW-1:0] w_year;

    assign w_sec  = rtce_pkg::decode_byte(i_raw.raw_second,  i_cfg.binary_mode);
    assign w_min  = rtce_pkg::decode_byte(i_raw.raw_minute,  i_cfg.binary_mode);
    assign w_wday = rtce_pkg::decode_byte(i_raw.raw_weekday, i_cfg.binary_mode);
    assign w_day  = rtce_pkg::decode_byte(i_raw.raw_day,     i_cfg.binary_mode);
    assign w_mon  = rtce_pkg::decode_byte(i_raw.raw_month,   i_cfg.binary_mode);
    assign w_yy   = rtce_pkg::decode_byte(i_raw.raw_year,    i_cfg.binary_mode);

    assign w_h24  = rtce_pkg::decode_byte(i_raw.raw_hour, i_cfg.binary_mode);
    assign w_h12  = rtce_pkg::decode_byte({1'b0, i_raw.raw_hour[6:0]}, i_cfg.binary_mode);
    assign w_h12z = (w_h12 == 8'd12) ? 8'd0 : w_h12;

    always_comb begin
        if (i_cfg.hour_24_mode) begin
            w_hour = w_h24;
        end else begin
            w_hour = w_h12z + (i_raw.raw_hour[7] ? 8'd12 : 8'd0);
        end
    end

    always_comb begin
        if (i_cfg.century != '0) begin
            w_year = rtce_pkg::YearW'(w_yy)
                   + rtce_pkg::YearW'(i_cfg.century) * rtce_pkg::YearW'(100);
        end else if (w_yy < rtce_pkg::WINDOW_YEAR) begin
            w_year = rtce_pkg::YEAR_2000 + rtce_pkg::YearW'(w_yy);
        end else begin
            w_year = rtce_pkg::YEAR_1900 + rtce_pkg::YearW'(w_yy);
        end
    end

    always_comb begin
        o_fld                  = '0;
        o_fld.full_year        = w_year;
        o_fld.month_number     = w_mon;
        o_fld.day_of_month     = w_day;
        o_fld.day_of_week      = w_wday;
        o_fld.hour_of_day      = w_hour;
        o_fld.minute_of_hour   = w_min;
        o_fld.second_of_minute = w_sec;
        o_fld.date_valid       = (w_mon >= 8'd1) && (w_mon <= 8'd12) && (w_day != 8'd0);
    end

endmodule

// ----- rtl/rtc_registers_to_epoch_seconds.sv -----
// ============================================================================
// rtc_registers_to_epoch_seconds
// Clock-chip register snapshot to seconds since 1970-01-01 00:00:00.
// ============================================================================
// A snapshot is taken whenever start is high; busy is always low, so one
// snapshot per cycle is accepted. Each result appears on o_res for one cycle
// with o_valid after five register stages, in order: decode, leap-count
// quotients, day count, day-to-seconds multiply, final add. There is no
// backpressure: the result must be captured in the cycle o_valid is high.
// Write configuration only when no conversion is in flight.
module rtc_registers_to_epoch_seconds (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  rtce_pkg::t_rtc_in                   i_data,
    output logic                                o_valid,
    output rtce_pkg::t_rtc_out                  o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [rtce_pkg::CfgIdxW-1:0]        i_cfg_index,
    input  logic [rtce_pkg::CfgDataW-1:0]       i_cfg_data
);

    localparam int unsigned YW = rtce_pkg::YearW;
    localparam int unsigned DW = rtce_pkg::DaysW;

    rtce_pkg::t_rtc_cfg r_cfg;
    rtce_pkg::t_rtc_out w_dec;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    rtce_pkg::t_rtc_out r_f1, r_f2, r_f3, r_f4, r_f5;
    rtce_pkg::t_rtc_out n_f5;

    // stage 2 payload
    logic [7:0]    r_qa, r_qb, r_qc, r_qd;
    logic [11:0]   r_qy;
    logic [DW-1:0] r_ydays;
    logic [8:0]    r_cum;
    logic          r_after;
    // stage 3/4 payload
    logic [DW-1:0]                r_days;
    logic [rtce_pkg::HmsW-1:0]    r_hms3, r_hms4;
    logic [rtce_pkg::EpochW-1:0]  r_dsec;

    logic [YW-1:0] w_y, w_y1;
    logic [23:0]   w_pa, w_pb, w_pc, w_pd;
    logic [11:0]   w_leaps, w_c25;
    logic          w_leap;
    logic [DW-1:0] w_days;
    logic [rtce_pkg::HmsW-1:0] w_hms;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.binary_mode  <= 1'b0;
            r_cfg.hour_24_mode <= 1'b1;
            r_cfg.century      <= 7'd20;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rtce_pkg::CFG_BINARY_MODE:  r_cfg.binary_mode  <= i_cfg_data[0];
                rtce_pkg::CFG_HOUR_24_MODE: r_cfg.hour_24_mode <= i_cfg_data[0];
                rtce_pkg::CFG_CENTURY:      r_cfg.century      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rtce_decode u_decode (
        .i_cfg (r_cfg),
        .i_raw (i_data),
        .o_fld (w_dec)
    );

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    // stage 2: quotients by 100 and 400 via divide-by-25 reciprocal
    assign w_y  = r_f1.full_year;
    assign w_y1 = w_y - YW'(1);
    assign w_pa = 24'(w_y1[YW-1:2]) * 24'(rtce_pkg::RECIP_25);
    assign w_pb = 24'(w_y1[YW-1:4]) * 24'(rtce_pkg::RECIP_25);
    assign w_pc = 24'(w_y[YW-1:2])  * 24'(rtce_pkg::RECIP_25);
    assign w_pd = 24'(w_y[YW-1:4])  * 24'(rtce_pkg::RECIP_25);

    // stage 3: day count
    assign w_leaps = r_qy - 12'(r_qa) + 12'(r_qb) - rtce_pkg::LEAPS_BEFORE_EPOCH;
    assign w_c25   = 12'(r_qc) * 12'd25;
    assign w_leap  = ((r_f2.full_year[1:0] == 2'd0) && (r_f2.full_year[YW-1:2] != w_c25))
                  || ((r_f2.full_year[3:0] == 4'd0)
                      && (r_f2.full_year[YW-1:4] == 10'(12'(r_qd) * 12'd25)));
    assign w_days  = r_ydays
                   + (r_after ? DW'(w_leaps) : DW'(0))
                   + DW'(r_cum)
                   + DW'((w_leap && (r_f2.month_number > 8'd2)) ? 1'b1 : 1'b0)
                   + DW'(r_f2.day_of_month) - DW'(1);
    assign w_hms   = rtce_pkg::HmsW'(r_f2.hour_of_day) * rtce_pkg::HmsW'(3600)
                   + rtce_pkg::HmsW'(r_f2.minute_of_hour) * rtce_pkg::HmsW'(60)
                   + rtce_pkg::HmsW'(r_f2.second_of_minute);

    always_comb begin
        n_f5               = r_f4;
        n_f5.epoch_seconds = r_f4.date_valid
                           ? (r_dsec + rtce_pkg::EpochW'(r_hms4)) : '0;
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= w_dec;

        r_f2    <= r_f1;
        r_qa    <= w_pa[23:16];
        r_qb    <= w_pb[23:16];
        r_qc    <= w_pc[23:16];
        r_qd    <= w_pd[23:16];
        r_qy    <= w_y1[YW-1:2];
        r_after <= w_y > rtce_pkg::EPOCH_YEAR;
        r_ydays <= (w_y > rtce_pkg::EPOCH_YEAR)
                 ? DW'(w_y - rtce_pkg::EPOCH_YEAR) * DW'(365) : DW'(0);
        r_cum   <= rtce_pkg::month_offset(r_f1.month_number[3:0]);

        r_f3   <= r_f2;
        r_days <= w_days;
        r_hms3 <= w_hms;

        r_f4   <= r_f3;
        r_dsec <= rtce_pkg::EpochW'(r_days) * rtce_pkg::EpochW'(rtce_pkg::SECS_PER_DAY);
        r_hms4 <= r_hms3;

        r_f5 <= n_f5;
    end

    assign o_valid = r_v5;
    assign o_res   = r_f5;

    a_pipe_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |=> o_valid)
        else $error("pipeline lost a transaction");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_res.date_valid) |-> (o_res.epoch_seconds == '0))
        else $error("invalid date with nonzero seconds");

    a_valid_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.date_valid) |->
            (o_res.month_number >= 8'd1 && o_res.month_number <= 8'd12
             && o_res.day_of_month != 8'd0))
        else $error("date flagged valid with bad month or day");

endmodule
